/* hdl/pcfm_pkg.sv */
// Package for the peak counter and first-minimum locator.
// Holds the shared widths, default parameters, register index codes and the result struct.
// No dependencies.
package pcfm_pkg;

  // Default module parameters.
  localparam int unsigned MaxLenDefault     = 1024;
  localparam int unsigned SampleBitsDefault = 16;

  // Fixed widths of the configuration and result fields.
  localparam int unsigned StepW     = 16;
  localparam int unsigned OutW      = 10;
  localparam int unsigned CfgIdxW   = 1;
  localparam logic [OutW-1:0] CountMax = '1;

  // Reset values of the step registers.
  localparam logic [StepW-1:0] StrongStepReset = StepW'(30);
  localparam logic [StepW-1:0] WeakStepReset   = StepW'(20);

  typedef logic [StepW-1:0] step_t;
  typedef logic [OutW-1:0]  field10_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_STRONG_STEP = 1'b0,
    REG_WEAK_STEP   = 1'b1
  } cfg_reg_t;

  // Both rise thresholds, handed to the sequence tracker.
  typedef struct packed {
    step_t strong_step;
    step_t weak_step;
  } steps_t;

  // One result item.
  typedef struct packed {
    logic     peak_found;
    field10_t first_peak_index;
    field10_t peak_count;
    logic     min_found;
    field10_t min_index;
    logic     overflow;
  } result_t;

endpackage

/* hdl/pcfm_peak_test.sv */
// Peak test for one candidate sample under one rise threshold.
// Purely combinational; depends on pcfm_pkg for the step width.
module pcfm_peak_test #(
  parameter int unsigned SAMPLE_BITS = pcfm_pkg::SampleBitsDefault
) (
  input  logic [SAMPLE_BITS-1:0] center,
  input  logic [SAMPLE_BITS-1:0] left1,
  input  logic [SAMPLE_BITS-1:0] left2,
  input  logic [SAMPLE_BITS-1:0] right1,
  input  logic [SAMPLE_BITS-1:0] right2,
  input  logic                   has_right2,
  input  pcfm_pkg::step_t        step,
  output logic                   hit
);

  // One extra bit so that neighbor plus step never wraps.
  localparam int unsigned CmpW =
    ((SAMPLE_BITS > pcfm_pkg::StepW) ? SAMPLE_BITS : pcfm_pkg::StepW) + 1;

  logic [CmpW-1:0] center_x;
  logic [CmpW-1:0] step_x;
  logic            rise_l1, rise_l2, rise_r1, rise_r2;

  assign center_x = CmpW'(center);
  assign step_x   = CmpW'(step);

  assign rise_l1 = center_x >= (CmpW'(left1) + step_x);
  assign rise_l2 = center_x >= (CmpW'(left2) + step_x);
  assign rise_r1 = center_x >= (CmpW'(right1) + step_x);
  assign rise_r2 = center_x >= (CmpW'(right2) + step_x);

  assign hit = (rise_l1 | rise_l2) & (rise_r1 | (has_right2 & rise_r2));

endmodule

/* hdl/pcfm_seq_tracker.sv */
// Per-sequence state: sample window, index, running minimum and maximum, peak counts.
// Produces the result of the item being processed; depends on pcfm_pkg and pcfm_peak_test.
module pcfm_seq_tracker #(
  parameter int unsigned MAX_LEN     = pcfm_pkg::MaxLenDefault,
  parameter int unsigned SAMPLE_BITS = pcfm_pkg::SampleBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last,
  input  pcfm_pkg::steps_t       steps,
  output pcfm_pkg::result_t      result
);

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);
  localparam int unsigned IdxW = $clog2(MAX_LEN);

  typedef logic [SAMPLE_BITS-1:0] smp_t;
  typedef logic [IdxW-1:0]        pos_t;

  smp_t                 win_r [4];
  logic [CntW-1:0]      idx_r, idx_nxt;
  smp_t                 min_val_r, min_val_nxt;
  pos_t                 min_pos_r, min_pos_nxt;
  smp_t                 max_val_r, max_val_nxt;
  pcfm_pkg::field10_t   str_cnt_r, str_cnt_nxt, wk_cnt_r, wk_cnt_nxt;
  pos_t                 str_first_r, str_first_nxt, wk_first_r, wk_first_nxt;
  logic                 str_seen_r, str_seen_nxt, wk_seen_r, wk_seen_nxt;
  logic                 too_long_r, too_long_nxt;

  logic accepted, judge_a_en, judge_b_en;
  logic str_a_raw, str_b_raw, wk_a_raw, wk_b_raw;
  logic str_a, str_b, wk_a, wk_b;
  pos_t pos_a, pos_b;
  logic min_found;

  // Saturating add of up to two new peaks.
  function automatic pcfm_pkg::field10_t count_add(input pcfm_pkg::field10_t cnt,
                                                   input logic a, input logic b);
    logic [pcfm_pkg::OutW:0] sum;
    sum = {1'b0, cnt} + (pcfm_pkg::OutW + 1)'(a) + (pcfm_pkg::OutW + 1)'(b);
    if (sum > {1'b0, pcfm_pkg::CountMax}) begin
      count_add = pcfm_pkg::CountMax;
    end else begin
      count_add = sum[pcfm_pkg::OutW-1:0];
    end
  endfunction

  assign accepted   = idx_r < CntW'(MAX_LEN);
  // Interior candidate two back, with both right neighbors present.
  assign judge_a_en = accepted & (idx_r >= CntW'(4));
  // Final candidate one back, only its near right neighbor exists.
  assign judge_b_en = accepted & last & (idx_r >= CntW'(3));
  assign pos_a      = IdxW'(idx_r - CntW'(2));
  assign pos_b      = IdxW'(idx_r - CntW'(1));

  pcfm_peak_test #(.SAMPLE_BITS(SAMPLE_BITS)) u_str_a (
    .center(win_r[1]), .left1(win_r[2]), .left2(win_r[3]), .right1(win_r[0]),
    .right2(sample), .has_right2(1'b1), .step(steps.strong_step), .hit(str_a_raw)
  );
  pcfm_peak_test #(.SAMPLE_BITS(SAMPLE_BITS)) u_wk_a (
    .center(win_r[1]), .left1(win_r[2]), .left2(win_r[3]), .right1(win_r[0]),
    .right2(sample), .has_right2(1'b1), .step(steps.weak_step), .hit(wk_a_raw)
  );
  pcfm_peak_test #(.SAMPLE_BITS(SAMPLE_BITS)) u_str_b (
    .center(win_r[0]), .left1(win_r[1]), .left2(win_r[2]), .right1(sample),
    .right2('0), .has_right2(1'b0), .step(steps.strong_step), .hit(str_b_raw)
  );
  pcfm_peak_test #(.SAMPLE_BITS(SAMPLE_BITS)) u_wk_b (
    .center(win_r[0]), .left1(win_r[1]), .left2(win_r[2]), .right1(sample),
    .right2('0), .has_right2(1'b0), .step(steps.weak_step), .hit(wk_b_raw)
  );

  assign str_a = str_a_raw & judge_a_en;
  assign str_b = str_b_raw & judge_b_en;
  assign wk_a  = wk_a_raw & judge_a_en;
  assign wk_b  = wk_b_raw & judge_b_en;

  always_comb begin
    idx_nxt       = idx_r;
    min_val_nxt   = min_val_r;
    min_pos_nxt   = min_pos_r;
    max_val_nxt   = max_val_r;
    too_long_nxt  = too_long_r | ~accepted;

    str_cnt_nxt   = count_add(str_cnt_r, str_a, str_b);
    wk_cnt_nxt    = count_add(wk_cnt_r, wk_a, wk_b);
    str_seen_nxt  = str_seen_r | str_a | str_b;
    wk_seen_nxt   = wk_seen_r | wk_a | wk_b;

    // The earlier position wins when both candidates hit in one item.
    str_first_nxt = str_first_r;
    if (!str_seen_r && str_a) begin
      str_first_nxt = pos_a;
    end else if (!str_seen_r && str_b) begin
      str_first_nxt = pos_b;
    end
    wk_first_nxt = wk_first_r;
    if (!wk_seen_r && wk_a) begin
      wk_first_nxt = pos_a;
    end else if (!wk_seen_r && wk_b) begin
      wk_first_nxt = pos_b;
    end

    if (accepted) begin
      idx_nxt = idx_r + CntW'(1);
      if ((idx_r == '0) || (sample < min_val_r)) begin
        min_val_nxt = sample;
        min_pos_nxt = IdxW'(idx_r);
      end
      if (sample > max_val_r) begin
        max_val_nxt = sample;
      end
    end
  end

  assign min_found = min_val_nxt < max_val_nxt;

  always_comb begin
    result.peak_found = str_seen_nxt | wk_seen_nxt;
    if (str_seen_nxt) begin
      result.first_peak_index = pcfm_pkg::field10_t'(str_first_nxt);
      result.peak_count       = str_cnt_nxt;
    end else if (wk_seen_nxt) begin
      result.first_peak_index = pcfm_pkg::field10_t'(wk_first_nxt);
      result.peak_count       = wk_cnt_nxt;
    end else begin
      result.first_peak_index = '0;
      result.peak_count       = wk_cnt_nxt;
    end
    result.min_found = min_found;
    result.min_index = min_found ? pcfm_pkg::field10_t'(min_pos_nxt) : '0;
    result.overflow  = too_long_nxt;
  end

  // A sequence ends on its last item: every field goes back to its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n || (go && last)) begin
      for (int k = 0; k < 4; k++) begin
        win_r[k] <= '0;
      end
      idx_r       <= '0;
      min_val_r   <= '1;
      min_pos_r   <= '0;
      max_val_r   <= '0;
      str_cnt_r   <= '0;
      str_first_r <= '0;
      str_seen_r  <= 1'b0;
      wk_cnt_r    <= '0;
      wk_first_r  <= '0;
      wk_seen_r   <= 1'b0;
      too_long_r  <= 1'b0;
    end else if (go) begin
      if (accepted) begin
        win_r[3] <= win_r[2];
        win_r[2] <= win_r[1];
        win_r[1] <= win_r[0];
        win_r[0] <= sample;
      end
      idx_r       <= idx_nxt;
      min_val_r   <= min_val_nxt;
      min_pos_r   <= min_pos_nxt;
      max_val_r   <= max_val_nxt;
      str_cnt_r   <= str_cnt_nxt;
      str_first_r <= str_first_nxt;
      str_seen_r  <= str_seen_nxt;
      wk_cnt_r    <= wk_cnt_nxt;
      wk_first_r  <= wk_first_nxt;
      wk_seen_r   <= wk_seen_nxt;
      too_long_r  <= too_long_nxt;
    end
  end

endmodule

/* hdl/peak_count_and_first_minimum_core.sv */
// Top level of the peak counter and first-minimum locator.
// Holds the input register, the step registers and the result register; depends on
// pcfm_pkg and pcfm_seq_tracker.
//
//   channel  | ports                                   | direction | handshake
//   ---------+-----------------------------------------+-----------+-----------------
//   input    | in_sample, in_last                      | in        | in_valid/in_stall
//   result   | out_peak_found .. out_overflow          | out       | out_valid/out_stall
//   config   | cfg_index, cfg_data                     | in        | cfg_we, no wait
//
// One item is taken every cycle unless in_stall is raised. An item waits in the input
// register, and then the sequence tracker folds it into the window and running state; an
// item marked last loads the result register as it leaves the input register, which
// raises out_valid. Reset is synchronous and clears all sequence state and the step
// registers. While a result waits under out_stall, items without last keep flowing; only
// an item with last waits in the input register, and then in_stall is raised.
module peak_count_and_first_minimum_core #(
  parameter int unsigned MAX_LEN     = pcfm_pkg::MaxLenDefault,
  parameter int unsigned SAMPLE_BITS = pcfm_pkg::SampleBitsDefault
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_BITS-1:0]           in_sample,
  input  logic                             in_last,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_peak_found,
  output logic [pcfm_pkg::OutW-1:0]        out_first_peak_index,
  output logic [pcfm_pkg::OutW-1:0]        out_peak_count,
  output logic                             out_min_found,
  output logic [pcfm_pkg::OutW-1:0]        out_min_index,
  output logic                             out_overflow,

  input  logic                             cfg_we,
  input  logic [pcfm_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [pcfm_pkg::StepW-1:0]       cfg_data
);

  // Input register.
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   s1_last_r;

  // Step registers.
  pcfm_pkg::steps_t steps_r;

  // Result register.
  logic              res_valid_r;
  pcfm_pkg::result_t res_r;
  pcfm_pkg::result_t res_nxt;

  logic out_free;
  logic proc_go;
  logic s1_load;

  // The result register is free when empty or being drained at this edge.
  assign out_free = ~res_valid_r | ~out_stall;
  // Only an item with last needs the result register to move on.
  assign proc_go  = s1_valid_r & (~s1_last_r | out_free);
  assign s1_load  = ~s1_valid_r | proc_go;
  assign in_stall = ~s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r.strong_step <= pcfm_pkg::StrongStepReset;
      steps_r.weak_step   <= pcfm_pkg::WeakStepReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcfm_pkg::REG_STRONG_STEP: steps_r.strong_step <= cfg_data;
        pcfm_pkg::REG_WEAK_STEP:   steps_r.weak_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  pcfm_seq_tracker #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (proc_go),
    .sample(s1_sample_r),
    .last  (s1_last_r),
    .steps (steps_r),
    .result(res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (proc_go && s1_last_r) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && s1_last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = res_valid_r;
  assign out_peak_found       = res_r.peak_found;
  assign out_first_peak_index = res_r.first_peak_index;
  assign out_peak_count       = res_r.peak_count;
  assign out_min_found        = res_r.min_found;
  assign out_min_index        = res_r.min_index;
  assign out_overflow         = res_r.overflow;

endmodule

/* hdl/pcfm_checker.sv */
// Port-level checks for peak_count_and_first_minimum_core, with the bind that attaches them.
// Depends on pcfm_pkg for field widths.
module pcfm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_peak_found,
  input logic [pcfm_pkg::OutW-1:0]    out_first_peak_index,
  input logic [pcfm_pkg::OutW-1:0]    out_peak_count,
  input logic                         out_min_found,
  input logic [pcfm_pkg::OutW-1:0]    out_min_index
);

  // A waiting result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_peak_count)
      && $stable(out_first_peak_index) && $stable(out_min_index))
    else $error("stalled result changed");

  // Input is held back only while a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // A last item that finds the result register free after it is accepted produces its result.
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("result missing after last item");

  // No peak means no count and no index.
  a_no_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_peak_found |-> out_peak_count == '0 && out_first_peak_index == '0)
    else $error("peak fields set without a peak");

  // No minimum means index zero.
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_min_found |-> out_min_index == '0)
    else $error("minimum index set without a minimum");

endmodule

bind peak_count_and_first_minimum_core pcfm_checker u_pcfm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_last             (in_last),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_peak_found      (out_peak_found),
  .out_first_peak_index(out_first_peak_index),
  .out_peak_count      (out_peak_count),
  .out_min_found       (out_min_found),
  .out_min_index       (out_min_index)
);

/* tb/peak_min_checker.sv */
// Checker for the peak counter and first-minimum locator: watches the input, result and
// register ports, predicts each result and compares it with what the block returns.
// Depends on pcfm_pkg for the widths, register codes and the result struct.
module peak_min_checker #(
  parameter int unsigned MAX_LEN     = pcfm_pkg::MaxLenDefault,
  parameter int unsigned SAMPLE_BITS = pcfm_pkg::SampleBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [SAMPLE_BITS-1:0]       in_sample,
  input  logic                         in_last,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_peak_found,
  input  logic [pcfm_pkg::OutW-1:0]    out_first_peak_index,
  input  logic [pcfm_pkg::OutW-1:0]    out_peak_count,
  input  logic                         out_min_found,
  input  logic [pcfm_pkg::OutW-1:0]    out_min_index,
  input  logic                         out_overflow,
  input  logic                         cfg_we,
  input  logic [pcfm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pcfm_pkg::StepW-1:0]   cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import pcfm_pkg::*;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  step_t            strong_step_q;
  step_t            weak_step_q;
  sample_t          win [4];
  int unsigned      sample_idx;
  sample_t          min_v;
  field10_t         min_pos;
  sample_t          max_v;
  field10_t         strong_count, strong_first;
  field10_t         weak_count, weak_first;
  logic             strong_seen, weak_seen;
  logic             too_long;
  result_t          expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic rises(int unsigned top, int unsigned other, int unsigned step);
    return top >= other + step;
  endfunction

  function automatic logic is_peak(int unsigned c, int unsigned l1, int unsigned l2,
                                   int unsigned r1, int unsigned r2, logic has_r2,
                                   int unsigned step);
    logic left_ok, right_ok;
    left_ok  = rises(c, l1, step) || rises(c, l2, step);
    right_ok = rises(c, r1, step) || (has_r2 && rises(c, r2, step));
    return left_ok && right_ok;
  endfunction

  // Test one candidate position under both thresholds.
  task automatic judge(sample_t c, sample_t l1, sample_t l2, sample_t r1, sample_t r2,
                       logic has_r2, field10_t pos);
    if (is_peak(c, l1, l2, r1, r2, has_r2, strong_step_q)) begin
      if (!strong_seen) begin
        strong_seen  = 1'b1;
        strong_first = pos;
      end
      if (strong_count != CountMax) strong_count++;
    end
    if (is_peak(c, l1, l2, r1, r2, has_r2, weak_step_q)) begin
      if (!weak_seen) begin
        weak_seen  = 1'b1;
        weak_first = pos;
      end
      if (weak_count != CountMax) weak_count++;
    end
  endtask

  task automatic clear_sequence();
    for (int k = 0; k < 4; k++) win[k] = '0;
    sample_idx   = 0;
    min_v        = '1;
    min_pos      = '0;
    max_v        = '0;
    strong_count = '0;
    strong_first = '0;
    strong_seen  = 1'b0;
    weak_count   = '0;
    weak_first   = '0;
    weak_seen    = 1'b0;
    too_long     = 1'b0;
  endtask

  // Fold one accepted sample into the sequence; a last sample yields the expected result.
  task automatic fold_sample(sample_t s, logic last);
    int unsigned j;
    result_t     r;
    j = sample_idx;
    if (j < MAX_LEN) begin
      if (j >= 4) judge(win[1], win[2], win[3], win[0], s, 1'b1, field10_t'(j - 2));
      // The final candidate has only its near right neighbor.
      if (last && j >= 3) judge(win[0], win[1], win[2], s, '0, 1'b0, field10_t'(j - 1));
      if (j == 0 || s < min_v) begin
        min_v   = s;
        min_pos = field10_t'(j);
      end
      if (s > max_v) max_v = s;
      win[3]     = win[2];
      win[2]     = win[1];
      win[1]     = win[0];
      win[0]     = s;
      sample_idx = j + 1;
    end else begin
      too_long = 1'b1;
    end
    if (last) begin
      r.peak_found       = strong_seen | weak_seen;
      r.first_peak_index = strong_seen ? strong_first : (weak_seen ? weak_first : '0);
      r.peak_count       = strong_seen ? strong_count : weak_count;
      r.min_found        = min_v < max_v;
      r.min_index        = (min_v < max_v) ? min_pos : '0;
      r.overflow         = too_long;
      expected_results   = {expected_results, r};
      clear_sequence();
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    result_t got;
    if (!rst_n) begin
      strong_step_q = StrongStepReset;
      weak_step_q   = WeakStepReset;
      clear_sequence();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_peak_found, out_first_peak_index, out_peak_count,
                out_min_found, out_min_index, out_overflow};
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display({"unexpected result item: found=%0d first=%0d count=%0d ",
                      "minf=%0d mini=%0d ovf=%0d"},
                     got.peak_found, got.first_peak_index, got.peak_count,
                     got.min_found, got.min_index, got.overflow);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.peak_found != exp_r.peak_found ||
              got.first_peak_index != exp_r.first_peak_index ||
              got.peak_count != exp_r.peak_count ||
              got.min_found != exp_r.min_found ||
              got.min_index != exp_r.min_index ||
              got.overflow != exp_r.overflow) begin
            if (fail_count < 10)
              $display({"result mismatch: expected found=%0d first=%0d count=%0d minf=%0d ",
                        "mini=%0d ovf=%0d, got found=%0d first=%0d count=%0d minf=%0d ",
                        "mini=%0d ovf=%0d"},
                       exp_r.peak_found, exp_r.first_peak_index, exp_r.peak_count,
                       exp_r.min_found, exp_r.min_index, exp_r.overflow,
                       got.peak_found, got.first_peak_index, got.peak_count,
                       got.min_found, got.min_index, got.overflow);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_STRONG_STEP: strong_step_q = cfg_data;
          REG_WEAK_STEP:   weak_step_q   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) fold_sample(in_sample, in_last);
    end
    pending <= expected_results.size();
  end

endmodule

/* tb/tb_top.sv */
// Top of the testbench for peak_count_and_first_minimum_core: clock, reset, stimulus and verdict.
// Depends on pcfm_pkg, the block itself and peak_min_checker, which predicts and compares.
module tb_top;
  import pcfm_pkg::*;

  // All block inputs start at known values; every later change is a nonblocking
  // assignment at a rising edge, so the block and the checker see stable values.
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [StepW-1:0]     in_sample = '0;
  logic                 in_last   = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_peak_found;
  logic [OutW-1:0]      out_first_peak_index;
  logic [OutW-1:0]      out_peak_count;
  logic                 out_min_found;
  logic [OutW-1:0]      out_min_index;
  logic                 out_overflow;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [StepW-1:0]     cfg_data  = '0;
  int                   fail_count;
  int                   pending;

  // Idle odds in percent per cycle for the sender and the receiver, set per phase.
  int                   send_idle_pct = 0;
  int                   stall_pct     = 0;

  // The thresholds the block currently holds, used to aim samples at the compare edges.
  int unsigned          cur_strong = StrongStepReset;
  int unsigned          cur_weak   = WeakStepReset;

  logic [StepW-1:0]     seq [$];

  always #5 clk = ~clk;

  peak_count_and_first_minimum_core u_dut (.*);

  peak_min_checker u_checker (.*);

  // The receiver stalls at random; the odds follow the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one sample and hold it until the block takes it. The call returns at the edge
  // that accepted the item, so valid stays high if the next item follows at once.
  task automatic send_sample(input logic [StepW-1:0] s, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_last   <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Play the queued samples as one sequence, last flag on the final one.
  task automatic send_seq();
    for (int k = 0; k < seq.size(); k++) send_sample(seq[k], k == seq.size() - 1);
  endtask

  // Wait until every predicted result has come back, then let the pipeline run dry.
  // The opening wait lets the checker's count catch up with the final item.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both thresholds; only ever called with the block idle.
  task automatic set_steps(input int unsigned strong_val, input int unsigned weak_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STRONG_STEP;
    cfg_data  <= StepW'(strong_val);
    @(posedge clk);
    cfg_index <= REG_WEAK_STEP;
    cfg_data  <= StepW'(weak_val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_strong = strong_val;
    cur_weak   = weak_val;
  endtask

  // A long sequence, either alternating low and high or fully random.
  task automatic send_long(input int len, input logic alternate);
    for (int k = 0; k < len; k++)
      send_sample(alternate ? ((k % 2) ? StepW'(200) : '0) : StepW'($urandom_range(0, 65535)),
                  k == len - 1);
  endtask

  // Pick a sample. Style 0 spans the whole range, style 1 sits a threshold, one less or
  // one more away from a base so the rise compares land on their edges, and style 2 keeps
  // to a tiny range so ties and repeated minima are common.
  function automatic logic [StepW-1:0] pick_sample(input int style);
    int base;
    int d;
    int v;
    case (style)
      0: begin
        case ($urandom_range(9))
          0:       v = 0;
          1:       v = 65535;
          default: v = $urandom_range(0, 65535);
        endcase
      end
      1: begin
        case ($urandom_range(3))
          0:       base = 0;
          1:       base = $urandom_range(0, 400);
          2:       base = $urandom_range(0, 65535);
          default: base = 65535 - $urandom_range(0, 400);
        endcase
        case ($urandom_range(6))
          0:       d = 0;
          1:       d = int'(cur_weak) - 1;
          2:       d = int'(cur_weak);
          3:       d = int'(cur_strong) - 1;
          4:       d = int'(cur_strong);
          5:       d = int'(cur_strong) + 1;
          default: d = $urandom_range(0, 2 * cur_strong + 2);
        endcase
        v = $urandom_range(1) ? base + d : base - d;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      default: v = $urandom_range(0, 3);
    endcase
    return StepW'(v);
  endfunction

  initial begin
    int phase_items;
    int len;
    int style;
    int r;

    // Synchronous reset, applied once at the start.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sequences under the reset thresholds, no idling on either side.
    // A single sample and a three-sample sequence leave no candidate at all.
    seq = '{16'd5};
    send_seq();
    seq = '{16'd0, 16'd100, 16'd0};
    send_seq();
    // Four samples: the only candidate is the final one, which lacks a far right neighbor.
    seq = '{16'd0, 16'd0, 16'd100, 16'd0};
    send_seq();
    // A constant sequence has no minimum below its maximum.
    seq = '{16'd7, 16'd7, 16'd7, 16'd7, 16'd7};
    send_seq();
    // A rise that clears only the weak threshold, so the fallback is reported.
    seq = '{16'd0, 16'd0, 16'd25, 16'd0, 16'd0};
    send_seq();
    // Sample extremes; the repeated minimum must report its first position.
    seq = '{16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535};
    send_seq();
    seq = '{16'd65535, 16'd65535, 16'd65535};
    send_seq();
    settle();

    // A zero threshold takes any rise, even none.
    set_steps(0, 0);
    seq = '{16'd4, 16'd4, 16'd4, 16'd4, 16'd4, 16'd4};
    send_seq();
    settle();

    // The largest threshold only passes a full-scale rise from zero.
    set_steps(65535, 65535);
    seq = '{16'd0, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd0, 16'd1};
    send_seq();
    settle();

    // One sample past the length limit: the final sample itself is dropped, the
    // last-candidate test is skipped and overflow is reported.
    set_steps(30, 20);
    send_long(MaxLenDefault + 1, 1'b1);
    settle();

    // Random phases: each pairs an idling pattern with a threshold setting.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      case (p)
        0: set_steps(30, 20);
        1: set_steps(1, 1);
        2: set_steps(65535, 65535);
        3: set_steps($urandom_range(1, 200), $urandom_range(1, 200));
        4: set_steps(5, 40);
        5: set_steps(0, $urandom_range(0, 3));
        6: set_steps($urandom_range(1, 65535), $urandom_range(1, 65535));
        default: set_steps(30, 20);
      endcase
      phase_items = 0;
      while (phase_items < 66) begin
        r = $urandom_range(99);
        if (r < 10)      len = $urandom_range(1, 3);
        else if (r < 85) len = $urandom_range(4, 24);
        else             len = $urandom_range(25, 80);
        style = $urandom_range(2);
        for (int k = 0; k < len; k++) send_sample(pick_sample(style), k == len - 1);
        phase_items += len;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
